// ===== hw/rtl/odd_even_transposition_sort_top_defines.svh =====
// Assertion macros used by the sorter datapath RTL.
`ifndef ODD_EVEN_TRANSPOSITION_SORT_TOP_DEFINES_SVH
`define ODD_EVEN_TRANSPOSITION_SORT_TOP_DEFINES_SVH

// Same-cycle implication.
`define OETS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("oets assertion failed");

// Next-cycle implication.
`define OETS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("oets assertion failed");

`endif

// ===== hw/rtl/oets_pkg.sv =====
`timescale 1ns / 1ps

package oets_pkg;

  localparam int DEFAULT_MAX_ELEMENTS = 64;
  localparam int VALUE_W = 32;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } in_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      end_of_set;
    logic                      overflow;
  } out_req_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic sort;
    logic shift;
  } dp_cmd_t;

  typedef struct packed {
    logic phase_done;
    logic emit_last;
  } dp_status_t;

endpackage

// ===== hw/rtl/oets_ctrl.sv =====
`timescale 1ns / 1ps

module oets_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output oets_pkg::dp_cmd_t   cmd_o,
  input  oets_pkg::dp_status_t status_i
);

  oets_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oets_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      oets_pkg::ST_LOAD: begin
        if (in_valid_i && in_last_i) state_d = oets_pkg::ST_SORT;
      end
      oets_pkg::ST_SORT: begin
        if (status_i.phase_done) state_d = oets_pkg::ST_EMIT;
      end
      oets_pkg::ST_EMIT: begin
        if (!out_stall_i && status_i.emit_last) state_d = oets_pkg::ST_LOAD;
      end
      default: state_d = oets_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      oets_pkg::ST_LOAD: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      oets_pkg::ST_SORT: begin
        cmd_o.sort = 1'b1;
      end
      oets_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        cmd_o.shift = !out_stall_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

// ===== hw/rtl/oets_datapath.sv =====
`timescale 1ns / 1ps
`include "odd_even_transposition_sort_top_defines.svh"

module oets_datapath #(
  parameter int MAX_ELEMENTS = oets_pkg::DEFAULT_MAX_ELEMENTS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  oets_pkg::in_req_t    in_req_i,
  input  oets_pkg::dp_cmd_t    cmd_i,
  output oets_pkg::dp_status_t status_o,
  output oets_pkg::out_req_t   out_req_o
);

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_ELEMENTS);

  logic signed [oets_pkg::VALUE_W-1:0] store_q [MAX_ELEMENTS];
  logic signed [oets_pkg::VALUE_W-1:0] store_d [MAX_ELEMENTS];
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] phase_q, phase_d;
  logic             dropped_q, dropped_d;
  logic             full;

  assign full = (count_q == MaxCnt);

  // load, one transposition phase over active pairs, or shift toward entry 0
  always_comb begin
    store_d = store_q;
    if (cmd_i.load && !full) begin
      store_d[count_q[IDX_W-1:0]] = in_req_i.value;
    end else if (cmd_i.sort) begin
      for (int j = 0; j < MAX_ELEMENTS - 1; j++) begin
        if ((j[0] == phase_q[0]) && ((j + 1) < int'(count_q)) &&
            (store_q[j] > store_q[j+1])) begin
          store_d[j]   = store_q[j+1];
          store_d[j+1] = store_q[j];
        end
      end
    end else if (cmd_i.shift) begin
      for (int i = 0; i < MAX_ELEMENTS - 1; i++) begin
        store_d[i] = store_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    store_q <= store_d;
  end

  always_comb begin
    count_d   = count_q;
    phase_d   = phase_q;
    dropped_d = dropped_q;
    if (cmd_i.load) begin
      phase_d = '0;
      if (full) begin
        dropped_d = 1'b1;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else if (cmd_i.sort) begin
      phase_d = phase_q + 1'b1;
    end else if (cmd_i.shift) begin
      count_d = count_q - 1'b1;
      if (count_q == CNT_W'(1)) dropped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      phase_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      phase_q   <= phase_d;
      dropped_q <= dropped_d;
    end
  end

  assign status_o.phase_done = cmd_i.sort && (phase_q == (count_q - 1'b1));
  assign status_o.emit_last  = (count_q == CNT_W'(1));

  assign out_req_o.sorted_value = store_q[0];
  assign out_req_o.end_of_set   = (count_q == CNT_W'(1));
  assign out_req_o.overflow     = dropped_q;

  `OETS_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= MaxCnt)
  `OETS_ASSERT_IMP(a_sort_phase, clk_i, rst_ni, cmd_i.sort, phase_q < count_q)
  `OETS_ASSERT_NXT(a_emit_clear, clk_i, rst_ni, cmd_i.shift && (count_q == CNT_W'(1)),
                   (count_q == '0) && !dropped_q)
  `OETS_ASSERT_NXT(a_load_count, clk_i, rst_ni, cmd_i.load && !full,
                   count_q == ($past(count_q) + 1'b1))

endmodule

// ===== hw/rtl/odd_even_transposition_sort_top.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// in       input      in_valid_i/in_stall_o   oets_pkg::in_req_t
// out      output     out_valid_o/out_stall_i oets_pkg::out_req_t
//
// Load stores requests until full; the last request starts n transposition
// phases over the flop-based element store (n = elements held).
// Emit then shifts the store toward entry 0, one result per unstalled cycle.
// Input is stalled while sorting and emitting. Reset is asynchronous, active low;
// no clearing pass.

module odd_even_transposition_sort_top #(
  parameter int MAX_ELEMENTS = oets_pkg::DEFAULT_MAX_ELEMENTS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  oets_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output oets_pkg::out_req_t out_req_o
);

  oets_pkg::dp_cmd_t    cmd;
  oets_pkg::dp_status_t status;

  oets_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_req_i.last),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  oets_datapath #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_req_i (in_req_i),
    .cmd_i    (cmd),
    .status_o (status),
    .out_req_o(out_req_o)
  );

endmodule

// ===== bench/oets_checker.sv =====
`timescale 1ns / 1ps

module oets_checker import oets_pkg::*; #(
  parameter int MAX_ELEMENTS = DEFAULT_MAX_ELEMENTS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  in_req_t  in_req_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  out_req_t out_req_i,
  output int       pending_o,
  output int       errors_o
);

  logic signed [VALUE_W-1:0] held [MAX_ELEMENTS];
  int                        held_n;
  bit                        dropped;
  out_req_t                  sorted_due [$];
  int                        errors;

  initial begin
    pending_o = 0;
    errors_o  = 0;
    errors    = 0;
    held_n    = 0;
    dropped   = 1'b0;
  end

  task automatic report(input string msg);
    $display("%0t oets_checker: %s", $time, msg);
    errors++;
  endtask

  // store one element, or flag overflow when full; on the last one, sort and queue the whole set
  function automatic void take_element(input in_req_t req);
    int                        p;
    int                        j;
    logic signed [VALUE_W-1:0] t;
    out_req_t                  r;
    if (held_n < MAX_ELEMENTS) begin
      held[held_n] = req.value;
      held_n++;
    end else begin
      dropped = 1'b1;
    end
    if (req.last) begin
      for (p = 0; p < held_n; p++) begin
        for (j = p % 2; j + 1 < held_n; j += 2) begin
          if (held[j] > held[j+1]) begin
            t         = held[j];
            held[j]   = held[j+1];
            held[j+1] = t;
          end
        end
      end
      for (j = 0; j < held_n; j++) begin
        r.sorted_value = held[j];
        r.end_of_set   = (j == held_n - 1);
        r.overflow     = dropped;
        sorted_due.push_back(r);
      end
      held_n  = 0;
      dropped = 1'b0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_req_t want;
    if (!rst_ni) begin
      sorted_due.delete();
      held_n  = 0;
      dropped = 1'b0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        take_element(in_req_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (sorted_due.size() == 0) begin
          report($sformatf("result %0d arrived with none expected",
                           out_req_i.sorted_value));
        end else begin
          want = sorted_due.pop_front();
          if (out_req_i.sorted_value !== want.sorted_value) begin
            report($sformatf("sorted_value %0d, expected %0d",
                             out_req_i.sorted_value, want.sorted_value));
          end
          if (out_req_i.end_of_set !== want.end_of_set) begin
            report($sformatf("end_of_set %b, expected %b (value %0d)",
                             out_req_i.end_of_set, want.end_of_set, want.sorted_value));
          end
          if (out_req_i.overflow !== want.overflow) begin
            report($sformatf("overflow %b, expected %b (value %0d)",
                             out_req_i.overflow, want.overflow, want.sorted_value));
          end
        end
      end
    end
    pending_o <= sorted_due.size();
    errors_o  <= errors;
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import oets_pkg::*;

  localparam int CAP        = DEFAULT_MAX_ELEMENTS;
  localparam int ITEMS      = 450;
  localparam int IDLE_LIMIT = 4000;

  localparam int FLAVOR_WIDE   = 0;
  localparam int FLAVOR_NARROW = 1;
  localparam int FLAVOR_EDGE   = 2;
  localparam int FLAVOR_MIXED  = 3;

  typedef enum logic [1:0] {
    STALL_OFF,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_req_t     in_req_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_req_t    out_req_o;

  int          pending;
  int          errors;
  int          sent;
  int          burst_left;
  int          idle_cycles;
  logic [15:0] stall_tick;
  stall_mode_e stall_mode;

  initial begin
    clk_i = 1'b0;
  end

  always #10 clk_i = ~clk_i;

  odd_even_transposition_sort_top #(
    .MAX_ELEMENTS(CAP)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

  oets_checker #(
    .MAX_ELEMENTS(CAP)
  ) i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_i (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_i(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_i  (out_req_o),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  // receiver stall; a new random mode is picked whenever stall_tick[6:0] is zero
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1'b1;
    if (stall_tick[6:0] == '0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
    end
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      case (stall_mode)
        STALL_OFF:    out_stall_i <= 1'b0;
        STALL_LIGHT:  out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:  out_stall_i <= ($urandom_range(0, 3) != 0);
        default:      out_stall_i <= stall_tick[2];
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("odd_even_transposition_sort_top: mismatch");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_value(input int flavor);
    int f;
    f = (flavor == FLAVOR_MIXED) ? $urandom_range(FLAVOR_WIDE, FLAVOR_EDGE) : flavor;
    case (f)
      FLAVOR_NARROW: return $signed($urandom_range(0, 15)) - 8;
      FLAVOR_EDGE: begin
        case ($urandom_range(0, 4))
          0:       return 32'sh8000_0000;
          1:       return 32'sh7fff_ffff;
          2:       return 32'sh0000_0000;
          3:       return 32'shffff_ffff;
          default: return $urandom;
        endcase
      end
      default:     return $urandom;
    endcase
  endfunction

  task automatic send(input logic signed [31:0] v, input logic lst);
    int gap;
    in_req_i   <= '{value: v, last: lst};
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_set(input int len, input int flavor);
    int i;
    for (i = 0; i < len; i++) begin
      send(pick_value(flavor), i == len - 1);
    end
  endtask

  initial begin
    int set_idx;
    int len;
    int r;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    out_stall_i = 1'b0;
    rst_ni      = 1'b0;
    stall_tick  = '0;
    stall_mode  = STALL_OFF;
    idle_cycles = 0;
    sent        = 0;
    burst_left  = $urandom_range(1, 20);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-element sets at both extremes
    send(32'sh8000_0000, 1'b1);
    send(32'sh7fff_ffff, 1'b1);
    // pair needing a swap, then an equal pair
    send(32'sh7fff_ffff, 1'b0);
    send(32'sh8000_0000, 1'b1);
    send(32'sd5, 1'b0);
    send(32'sd5, 1'b1);
    // mixed signs with duplicates
    send(32'sd0, 1'b0);
    send(-32'sd1, 1'b0);
    send(32'sd1, 1'b0);
    send(32'sh8000_0000, 1'b0);
    send(32'sh7fff_ffff, 1'b0);
    send(-32'sd1, 1'b1);
    // already ascending
    send(-32'sd3, 1'b0);
    send(-32'sd2, 1'b0);
    send(-32'sd1, 1'b0);
    send(32'sd0, 1'b1);
    // descending
    send(32'sd40, 1'b0);
    send(32'sd30, 1'b0);
    send(32'sd20, 1'b0);
    send(32'sd10, 1'b0);
    send(-32'sd10, 1'b1);

    // full store, then overflow by one and by six requests (extra ones dropped), then random sets
    set_idx = 0;
    while (sent < ITEMS) begin
      case (set_idx)
        0:       len = CAP;
        1:       len = CAP + 1;
        2:       len = CAP + 6;
        default: begin
          r = $urandom_range(0, 19);
          if (r < 15) len = $urandom_range(1, 8);
          else if (r < 19) len = $urandom_range(9, CAP - 1);
          else len = $urandom_range(CAP, CAP + 3);
        end
      endcase
      send_set(len, $urandom_range(FLAVOR_WIDE, FLAVOR_MIXED));
      set_idx++;
    end
    if (in_valid_i) begin
      in_valid_i <= 1'b0;
    end

    do @(posedge clk_i); while (pending != 0);
    repeat (4 * CAP) @(posedge clk_i);
    if (errors == 0) begin
      $display("odd_even_transposition_sort_top: match");
    end else begin
      $display("odd_even_transposition_sort_top: mismatch");
    end
    $finish;
  end

endmodule
